>>> rtl/core/kl_resp_pkg.sv
`timescale 1ns / 1ps

package kl_resp_pkg;

  // Request and response tables: rows of up to eight bytes, unused bytes are zero.
  localparam int ROM_ROWS = 23;
  localparam int ROW_BYTES = 8;
  localparam int ROW_W = $clog2(ROM_ROWS);
  localparam int COL_W = $clog2(ROW_BYTES);
  localparam int ENTRY_W = 5;
  localparam int DEF_NUM_REQUESTS = 23;

  // Result buffer sizing: an input byte causes at most three line bytes.
  localparam int MAX_RESULTS = 3;
  localparam int CNT_W = 2;

  localparam logic [7:0] SEQ_RESET = 8'd7;
  localparam logic [7:0] SEQ_STEP = 8'd2;
  localparam logic [8:0] ECHO_SUM = 9'h0FF;
  localparam logic [ENTRY_W-1:0] ENTRY_END_SESSION = 5'd1;
  localparam logic [ENTRY_W-1:0] ENTRY_NO_DATA = 5'd0;

  // Where a transmitted byte comes from.
  typedef enum logic [1:0] {
    SRC_LOOP = 2'd0,
    SRC_ACK  = 2'd1,
    SRC_RESP = 2'd2,
    SRC_NONE = 2'd3
  } src_t;

  typedef logic [7:0] row_t [ROW_BYTES];

  localparam row_t REQ_ROM [ROM_ROWS] = '{
    '{8'h03, 8'h00, 8'h09, 8'h03, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h03, 8'h00, 8'h06, 8'h03, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h06, 8'h00, 8'h03, 8'h0D, 8'h00, 8'h00, 8'h03, 8'h00},
    '{8'h04, 8'h00, 8'h08, 8'h00, 8'h03, 8'h00, 8'h00, 8'h00},
    '{8'h04, 8'h00, 8'h08, 8'h01, 8'h03, 8'h00, 8'h00, 8'h00},
    '{8'h04, 8'h00, 8'h08, 8'h02, 8'h03, 8'h00, 8'h00, 8'h00},
    '{8'h04, 8'h00, 8'h08, 8'h03, 8'h03, 8'h00, 8'h00, 8'h00},
    '{8'h03, 8'h00, 8'h05, 8'h03, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h04, 8'h00, 8'h08, 8'h04, 8'h03, 8'h00, 8'h00, 8'h00},
    '{8'h04, 8'h00, 8'h08, 8'h05, 8'h03, 8'h00, 8'h00, 8'h00},
    '{8'h04, 8'h00, 8'h08, 8'h07, 8'h03, 8'h00, 8'h00, 8'h00},
    '{8'h03, 8'h00, 8'h07, 8'h03, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h06, 8'h00, 8'h01, 8'h01, 8'h00, 8'h3a, 8'h03, 8'h00},
    '{8'h06, 8'h00, 8'h01, 8'h01, 8'h00, 8'h20, 8'h03, 8'h00},
    '{8'h06, 8'h00, 8'h01, 8'h01, 8'h00, 8'h42, 8'h03, 8'h00},
    '{8'h06, 8'h00, 8'h01, 8'h02, 8'h00, 8'h62, 8'h03, 8'h00},
    '{8'h06, 8'h00, 8'h01, 8'h01, 8'h00, 8'h22, 8'h03, 8'h00},
    '{8'h06, 8'h00, 8'h01, 8'h01, 8'h00, 8'h29, 8'h03, 8'h00},
    '{8'h06, 8'h00, 8'h01, 8'h01, 8'h01, 8'h90, 8'h03, 8'h00},
    '{8'h06, 8'h00, 8'h01, 8'h01, 8'h01, 8'hb0, 8'h03, 8'h00},
    '{8'h04, 8'h00, 8'h04, 8'h0e, 8'h03, 8'h00, 8'h00, 8'h00},
    '{8'h04, 8'h00, 8'h04, 8'h1f, 8'h03, 8'h00, 8'h00, 8'h00},
    '{8'h04, 8'h00, 8'h04, 8'h21, 8'h03, 8'h00, 8'h00, 8'h00}
  };

  localparam row_t RESP_ROM [ROM_ROWS] = '{
    '{8'h03, 8'h00, 8'h09, 8'h03, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h03, 8'h00, 8'h06, 8'h03, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h03, 8'h00, 8'h09, 8'h03, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h05, 8'h00, 8'hFB, 8'h00, 8'h06, 8'h03, 8'h00, 8'h00},
    '{8'h05, 8'h00, 8'hFB, 8'h00, 8'had, 8'h03, 8'h00, 8'h00},
    '{8'h05, 8'h00, 8'hFB, 8'h00, 8'hfd, 8'h03, 8'h00, 8'h00},
    '{8'h05, 8'h00, 8'hFB, 8'h00, 8'hfd, 8'h03, 8'h00, 8'h00},
    '{8'h03, 8'h00, 8'h09, 8'h03, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h05, 8'h00, 8'hFB, 8'h00, 8'h04, 8'h03, 8'h00, 8'h00},
    '{8'h05, 8'h00, 8'hFB, 8'h00, 8'h5c, 8'h03, 8'h00, 8'h00},
    '{8'h05, 8'h00, 8'hFB, 8'h00, 8'hfd, 8'h03, 8'h00, 8'h00},
    '{8'h04, 8'h00, 8'hFC, 8'h00, 8'h03, 8'h00, 8'h00, 8'h00},
    '{8'h04, 8'h00, 8'hFE, 8'h00, 8'h03, 8'h00, 8'h00, 8'h00},
    '{8'h04, 8'h00, 8'hFE, 8'h10, 8'h03, 8'h00, 8'h00, 8'h00},
    '{8'h04, 8'h00, 8'hFE, 8'h00, 8'h03, 8'h00, 8'h00, 8'h00},
    '{8'h05, 8'h00, 8'hFE, 8'h00, 8'h00, 8'h03, 8'h00, 8'h00},
    '{8'h04, 8'h00, 8'hFE, 8'h00, 8'h03, 8'h00, 8'h00, 8'h00},
    '{8'h04, 8'h00, 8'hFE, 8'h04, 8'h03, 8'h00, 8'h00, 8'h00},
    '{8'h04, 8'h00, 8'hFE, 8'h07, 8'h03, 8'h00, 8'h00, 8'h00},
    '{8'h04, 8'h00, 8'hFE, 8'hF7, 8'h03, 8'h00, 8'h00, 8'h00},
    '{8'h03, 8'h00, 8'h09, 8'h03, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h03, 8'h00, 8'h09, 8'h03, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h03, 8'h00, 8'h09, 8'h03, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  // Request table lookup; rows beyond the table read as zero.
  function automatic logic [7:0] req_at(input int row, input logic [COL_W-1:0] col);
    logic [7:0] val;
    val = 8'h00;
    if (row < ROM_ROWS) begin
      val = REQ_ROM[row[ROW_W-1:0]][col];
    end
    return val;
  endfunction

  // Response table lookup by selected entry.
  function automatic logic [7:0] resp_at(input logic [ENTRY_W-1:0] row,
                                         input logic [COL_W-1:0] col);
    logic [7:0] val;
    val = 8'h00;
    if (int'(row) < ROM_ROWS) begin
      val = RESP_ROM[row[ROW_W-1:0]][col];
    end
    return val;
  endfunction

endpackage

>>> rtl/core/k_line_ecu_packet_responder_core.sv
`timescale 1ns / 1ps

// The first line byte caused by a request is registered and appears in the cycle after it is accepted.
// A request causes one to three line bytes, which are buffered until the receiver takes them.
// A new request is taken in the cycle the last buffered byte leaves, so there is no gap.
// Reset (synchronous, active high) empties the output buffer and restarts the session.
module k_line_ecu_packet_responder_core
  import kl_resp_pkg::*;
#(
  parameter int NUM_REQUESTS = DEF_NUM_REQUESTS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  logic       operation,
  input  logic [7:0] line_byte,
  output logic       res_valid,
  input  logic       res_stall,
  output logic [7:0] out_byte,
  output logic [1:0] source,
  output logic       session_over,
  output logic       last
);

  typedef enum logic [1:0] {
    PH_LENGTH  = 2'd0,
    PH_RECEIVE = 2'd1,
    PH_RESPOND = 2'd2,
    PH_OVER    = 2'd3
  } phase_t;

  localparam logic [NUM_REQUESTS-1:0] ALL_CANDIDATES = '1;

  // Session state.
  phase_t                   phase, phase_next;
  logic [7:0]               byte_position, byte_position_next;
  logic [7:0]               request_length, request_length_next;
  logic [NUM_REQUESTS-1:0]  candidate_mask, candidate_mask_next;
  logic [ENTRY_W-1:0]       response_entry, response_entry_next;
  logic [7:0]               sequence_number, sequence_number_next;
  logic [7:0]               pending_byte, pending_byte_next;

  // Result buffer holding the line bytes of the last accepted request.
  logic [7:0]       buf_byte [MAX_RESULTS];
  src_t             buf_src [MAX_RESULTS];
  logic [CNT_W-1:0] buf_cnt;
  logic [CNT_W-1:0] buf_idx;
  logic             buf_over;

  logic [7:0]       new_byte [MAX_RESULTS];
  src_t             new_src [MAX_RESULTS];
  logic [CNT_W-1:0] new_cnt;

  logic                    take;
  logic                    drain_last;
  logic                    accept;
  logic [ENTRY_W-1:0]      sel_entry;
  logic [NUM_REQUESTS-1:0] len_mask;
  logic [NUM_REQUESTS-1:0] pos_mask;
  logic                    echo_ok;
  logic [7:0]              next_pos;
  logic [7:0]              next_resp;
  logic [7:0]              resp_len;

  // Handshake: a new request enters as the last buffered byte is taken.
  assign take       = res_valid && !res_stall;
  assign drain_last = take && (buf_idx == buf_cnt - CNT_W'(1));
  assign req_stall  = res_valid && !drain_last;
  assign accept     = req_valid && !req_stall;

  assign out_byte     = buf_byte[buf_idx];
  assign source       = buf_src[buf_idx];
  assign session_over = buf_over;
  assign last         = (buf_idx == buf_cnt - CNT_W'(1));

  // Matching helpers: entry selection, length filter and per-position filter.
  always_comb begin
    sel_entry = ENTRY_NO_DATA;
    for (int i = NUM_REQUESTS - 1; i >= 0; i--) begin
      if (candidate_mask[i]) begin
        sel_entry = ENTRY_W'(i);
      end
    end
    len_mask = '0;
    pos_mask = candidate_mask;
    for (int i = 0; i < NUM_REQUESTS; i++) begin
      if (i < ROM_ROWS && req_at(i, COL_W'(0)) == line_byte) begin
        len_mask[i] = 1'b1;
      end
      if (byte_position >= 8'(ROW_BYTES) ||
          req_at(i, byte_position[COL_W-1:0]) != line_byte) begin
        pos_mask[i] = 1'b0;
      end
    end
  end

  // Response side: echo check and the byte that follows the current one.
  always_comb begin
    echo_ok  = ({1'b0, pending_byte} + {1'b0, line_byte}) == ECHO_SUM;
    next_pos = byte_position + 8'd1;
    resp_len = resp_at(response_entry, COL_W'(0));
    if (next_pos == 8'd1) begin
      next_resp = sequence_number;
    end else if (next_pos >= 8'(ROW_BYTES)) begin
      next_resp = 8'h00;
    end else begin
      next_resp = resp_at(response_entry, next_pos[COL_W-1:0]);
    end
  end

  // Next state and line bytes for the offered request.
  always_comb begin
    phase_next           = phase;
    byte_position_next   = byte_position;
    request_length_next  = request_length;
    candidate_mask_next  = candidate_mask;
    response_entry_next  = response_entry;
    sequence_number_next = sequence_number;
    pending_byte_next    = pending_byte;
    new_cnt              = CNT_W'(1);
    for (int j = 0; j < MAX_RESULTS; j++) begin
      new_byte[j] = 8'h00;
      new_src[j]  = SRC_NONE;
    end

    if (phase == PH_OVER || operation) begin
      phase_next = PH_OVER;
    end else begin
      unique case (phase)
        PH_LENGTH: begin
          request_length_next = line_byte;
          candidate_mask_next = len_mask;
          new_byte[0] = line_byte;
          new_src[0]  = SRC_LOOP;
          new_byte[1] = ~line_byte;
          new_src[1]  = SRC_ACK;
          new_cnt     = CNT_W'(2);
          if (line_byte == 8'h00) begin
            // An empty request is answered at once with NoData.
            response_entry_next = ENTRY_NO_DATA;
            pending_byte_next   = resp_at(ENTRY_NO_DATA, COL_W'(0));
            byte_position_next  = 8'd0;
            phase_next          = PH_RESPOND;
            new_byte[2] = resp_at(ENTRY_NO_DATA, COL_W'(0));
            new_src[2]  = SRC_RESP;
            new_cnt     = CNT_W'(3);
          end else begin
            byte_position_next = 8'd1;
            phase_next         = PH_RECEIVE;
          end
        end
        PH_RECEIVE: begin
          new_byte[0] = line_byte;
          new_src[0]  = SRC_LOOP;
          new_cnt     = CNT_W'(2);
          if (byte_position < request_length) begin
            if (byte_position >= 8'd2) begin
              candidate_mask_next = pos_mask;
            end
            new_byte[1] = ~line_byte;
            new_src[1]  = SRC_ACK;
            byte_position_next = next_pos;
          end else begin
            // End byte: pick the lowest matching entry and start the answer.
            response_entry_next = sel_entry;
            pending_byte_next   = resp_at(sel_entry, COL_W'(0));
            byte_position_next  = 8'd0;
            phase_next          = PH_RESPOND;
            new_byte[1] = resp_at(sel_entry, COL_W'(0));
            new_src[1]  = SRC_RESP;
          end
        end
        PH_RESPOND: begin
          new_byte[0] = line_byte;
          new_src[0]  = SRC_LOOP;
          if (!echo_ok) begin
            phase_next = PH_OVER;
          end else begin
            new_byte[1] = next_resp;
            new_src[1]  = SRC_RESP;
            new_cnt     = CNT_W'(2);
            if (next_pos >= resp_len) begin
              if (response_entry == ENTRY_END_SESSION) begin
                phase_next = PH_OVER;
              end else begin
                sequence_number_next = sequence_number + SEQ_STEP;
                phase_next           = PH_LENGTH;
                byte_position_next   = 8'd0;
                candidate_mask_next  = ALL_CANDIDATES;
              end
            end else begin
              pending_byte_next  = next_resp;
              byte_position_next = next_pos;
            end
          end
        end
        default: begin
          phase_next = PH_OVER;
        end
      endcase
    end
  end

  // Session state and result buffer.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_LENGTH;
      byte_position   <= 8'd0;
      request_length  <= 8'd0;
      candidate_mask  <= ALL_CANDIDATES;
      response_entry  <= ENTRY_NO_DATA;
      sequence_number <= SEQ_RESET;
      pending_byte    <= 8'd0;
      res_valid       <= 1'b0;
      buf_idx         <= '0;
      buf_cnt         <= '0;
    end else if (accept) begin
      phase           <= phase_next;
      byte_position   <= byte_position_next;
      request_length  <= request_length_next;
      candidate_mask  <= candidate_mask_next;
      response_entry  <= response_entry_next;
      sequence_number <= sequence_number_next;
      pending_byte    <= pending_byte_next;
      res_valid       <= 1'b1;
      buf_idx         <= '0;
      buf_cnt         <= new_cnt;
    end else if (take) begin
      if (drain_last) begin
        res_valid <= 1'b0;
        buf_idx   <= '0;
      end else begin
        buf_idx <= buf_idx + CNT_W'(1);
      end
    end
  end

  // Buffer payload needs no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      buf_byte <= new_byte;
      buf_src  <= new_src;
      buf_over <= (phase_next == PH_OVER);
    end
  end

  // An accepted request always shows a result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> res_valid)
    else $error("accepted request produced no result");

  // The displayed slot always lies inside the filled part of the buffer.
  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (buf_cnt != '0) && (buf_idx < buf_cnt))
    else $error("result index outside buffer");

  // Once an ended session is reported, every later result reports it too.
  a_over_sticks: assert property (@(posedge clk) disable iff (rst)
    take && session_over |=> !res_valid || session_over)
    else $error("session restarted without reset");

  // A result with no source carries a zero byte.
  a_none_is_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && (source == SRC_NONE) |-> out_byte == 8'h00)
    else $error("nonzero byte with no source");

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import kl_resp_pkg::*;

  // Session phases as the device side of the link sees them.
  typedef enum logic [1:0] {
    AWAIT_LENGTH = 2'd0,
    RECEIVING    = 2'd1,
    RESPONDING   = 2'd2,
    SESSION_DONE = 2'd3
  } link_phase_t;

  // One byte the block puts on the line, with its markers.
  typedef struct packed {
    logic [7:0] out_byte;
    src_t       source;
    logic       session_over;
    logic       last;
  } line_result_t;

  // Tracks the link session and holds the line bytes each request should cause.
  class kline_session_model;
    link_phase_t          phase;
    logic [7:0]           position;
    logic [7:0]           req_len;
    logic [ROM_ROWS-1:0]  mask;
    logic [ENTRY_W-1:0]   entry;
    logic [7:0]           seq_num;
    logic [7:0]           pending;
    line_result_t         expected[$];
    line_result_t         batch[$];
    int                   errors;

    function new();
      phase = AWAIT_LENGTH;
      position = 8'd0;
      req_len = 8'd0;
      mask = '1;
      entry = ENTRY_NO_DATA;
      seq_num = SEQ_RESET;
      pending = 8'd0;
      errors = 0;
    endfunction

    function void emit(input logic [7:0] b, input src_t src);
      line_result_t r;
      r.out_byte = (src == SRC_NONE) ? 8'h00 : b;
      r.source = src;
      r.session_over = 1'b0;
      r.last = 1'b0;
      batch.push_back(r);
    endfunction

    // Byte 1 of every response carries the running sequence number.
    function logic [7:0] resp_byte(input logic [7:0] k);
      if (k == 8'd1) return seq_num;
      if (k >= ROW_BYTES || int'(entry) >= ROM_ROWS) return 8'h00;
      return RESP_ROM[entry][k[COL_W-1:0]];
    endfunction

    // The lowest surviving candidate wins; with none left, NoData is answered.
    function void start_response();
      entry = ENTRY_NO_DATA;
      for (int i = ROM_ROWS - 1; i >= 0; i--) begin
        if (mask[i]) entry = ENTRY_W'(i);
      end
      pending = resp_byte(8'd0);
      position = 8'd0;
      phase = RESPONDING;
      emit(pending, SRC_RESP);
    endfunction

    function void take_request(input logic op, input logic [7:0] b);
      logic [7:0] k;
      logic [7:0] v;
      batch = {};
      if (phase == SESSION_DONE || op) begin
        phase = SESSION_DONE;
        emit(8'h00, SRC_NONE);
      end else begin
        case (phase)
          AWAIT_LENGTH: begin
            req_len = b;
            mask = '0;
            for (int i = 0; i < ROM_ROWS; i++) begin
              if (REQ_ROM[i][0] == b) mask[i] = 1'b1;
            end
            emit(b, SRC_LOOP);
            emit(~b, SRC_ACK);
            if (b == 8'd0) begin
              start_response();
            end else begin
              position = 8'd1;
              phase = RECEIVING;
            end
          end
          RECEIVING: begin
            emit(b, SRC_LOOP);
            if (position < req_len) begin
              // Byte 1 is skipped; bytes past the table width never match.
              if (position >= 8'd2) begin
                for (int i = 0; i < ROM_ROWS; i++) begin
                  if (position >= ROW_BYTES) begin
                    mask[i] = 1'b0;
                  end else if (REQ_ROM[i][position[COL_W-1:0]] != b) begin
                    mask[i] = 1'b0;
                  end
                end
              end
              emit(~b, SRC_ACK);
              position = position + 8'd1;
            end else begin
              start_response();
            end
          end
          default: begin
            emit(b, SRC_LOOP);
            if (({1'b0, pending} + {1'b0, b}) != ECHO_SUM) begin
              phase = SESSION_DONE;
            end else begin
              k = position + 8'd1;
              v = resp_byte(k);
              emit(v, SRC_RESP);
              if (k >= resp_byte(8'd0)) begin
                if (entry == ENTRY_END_SESSION) begin
                  phase = SESSION_DONE;
                end else begin
                  seq_num = seq_num + SEQ_STEP;
                  phase = AWAIT_LENGTH;
                  position = 8'd0;
                  mask = '1;
                end
              end else begin
                pending = v;
                position = k;
              end
            end
          end
        endcase
      end
      foreach (batch[j]) begin
        batch[j].session_over = (phase == SESSION_DONE);
        batch[j].last = (j == batch.size() - 1);
        expected.push_back(batch[j]);
      end
    endfunction

    function void check_line_result(input logic [7:0] ob, input logic [1:0] src,
                                    input logic so, input logic lst);
      line_result_t want;
      if (expected.size() == 0) begin
        $error("unexpected line byte %0h from source %0d", ob, src);
        errors++;
        return;
      end
      want = expected.pop_front();
      if (ob !== want.out_byte) begin
        $error("out_byte: expected %0h, actual %0h", want.out_byte, ob);
        errors++;
      end
      if (src !== want.source) begin
        $error("source: expected %0d, actual %0d", want.source, src);
        errors++;
      end
      if (so !== want.session_over) begin
        $error("session_over: expected %0b, actual %0b", want.session_over, so);
        errors++;
      end
      if (lst !== want.last) begin
        $error("last: expected %0b, actual %0b", want.last, lst);
        errors++;
      end
    endfunction
  endclass

  localparam int SEND_IDLE[4] = '{0, 63, 0, 13};
  localparam int RECV_STALL[4] = '{0, 0, 63, 13};
  localparam int HOLD_CYCLES = 80;
  localparam int PHASE_REQUESTS = 38;

  logic       clk;
  logic       rst;
  logic       req_valid;
  logic       req_stall;
  logic       operation;
  logic [7:0] line_byte;
  logic       res_valid;
  logic       res_stall;
  logic [7:0] out_byte;
  logic [1:0] source;
  logic       session_over;
  logic       last;

  kline_session_model session;
  logic [7:0]         frame_buf[$];
  int                 send_idle_pct = 0;
  int                 recv_stall_pct = 0;
  int                 requests_sent = 0;
  int                 hold_trigger = 0;
  int                 hold_seen = 0;
  int                 hold_left = 0;

  k_line_ecu_packet_responder_core dut (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .operation    (operation),
    .line_byte    (line_byte),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .out_byte     (out_byte),
    .source       (source),
    .session_over (session_over),
    .last         (last)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else if (hold_left > 0) begin
      res_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_trigger) begin
      hold_seen <= hold_trigger;
      hold_left <= HOLD_CYCLES;
      res_stall <= 1'b1;
    end else begin
      res_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Every line byte taken from the block is checked against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      session.check_line_result(out_byte, source, session_over, last);
    end
  end

  // Offers one request and waits until the block takes it.
  task automatic send_request(input logic op, input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    operation <= op;
    line_byte <= b;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    session.take_request(op, b);
    requests_sent++;
  endtask

  task automatic send_bytes(input int count);
    int idx;
    for (idx = 0; idx < count; idx++) send_request(1'b0, frame_buf[idx]);
  endtask

  // Echoes every response byte back with its complement until the exchange ends.
  task automatic finish_response();
    while (session.phase == RESPONDING) send_request(1'b0, ~session.pending);
  endtask

  // A table request with random byte 1 and end byte, optionally with one byte spoiled.
  task automatic fill_table(input int row, input bit corrupt);
    int len;
    int idx;
    int spot;
    len = int'(REQ_ROM[row][0]);
    frame_buf = {};
    for (idx = 0; idx <= len; idx++) frame_buf.push_back(REQ_ROM[row][idx]);
    frame_buf[1] = 8'($urandom_range(0, 255));
    frame_buf[len] = 8'($urandom_range(0, 255));
    if (corrupt) begin
      spot = $urandom_range(2, len - 1);
      frame_buf[spot] = frame_buf[spot] ^ 8'($urandom_range(1, 255));
    end
  endtask

  task automatic fill_random(input int len);
    int idx;
    frame_buf = {};
    frame_buf.push_back(8'(len));
    for (idx = 0; idx < len; idx++) frame_buf.push_back(8'($urandom_range(0, 255)));
  endtask

  // Full request and response; steers clear of EndSession so the session stays live.
  task automatic run_exchange();
    if (frame_buf.size() > 2 && frame_buf[0] == REQ_ROM[ENTRY_END_SESSION][0] &&
        frame_buf[2] == REQ_ROM[ENTRY_END_SESSION][2]) begin
      frame_buf[2] = frame_buf[2] ^ 8'h01;
    end
    send_bytes(frame_buf.size());
    finish_response();
  endtask

  task automatic pick_row(output int row);
    do row = $urandom_range(0, ROM_ROWS - 1); while (row == ENTRY_END_SESSION);
  endtask

  task automatic random_exchange();
    int pick;
    int row;
    pick = $urandom_range(0, 9);
    pick_row(row);
    if (pick < 6) fill_table(row, 1'b0);
    else if (pick < 8) fill_table(row, 1'b1);
    else if ($urandom_range(0, 9) == 0) fill_random($urandom_range(9, 40));
    else fill_random($urandom_range(0, 8));
    run_exchange();
  endtask

  // Ends the live session by EndSession, a bad echo or a host timeout.
  task automatic end_session();
    int row;
    int echo_idx;
    int bad_at;
    pick_row(row);
    case ($urandom_range(0, 2))
      0: begin
        fill_table(int'(ENTRY_END_SESSION), 1'b0);
        send_bytes(frame_buf.size());
        finish_response();
      end
      1: begin
        fill_table(row, 1'b0);
        send_bytes(frame_buf.size());
        echo_idx = 0;
        bad_at = $urandom_range(0, 2);
        while (session.phase == RESPONDING) begin
          if (echo_idx == bad_at) begin
            send_request(1'b0, ~session.pending ^ 8'($urandom_range(1, 255)));
          end else begin
            send_request(1'b0, ~session.pending);
          end
          echo_idx++;
        end
      end
      default: begin
        fill_table(row, 1'b0);
        send_bytes($urandom_range(0, frame_buf.size()));
        send_request(1'b1, 8'($urandom_range(0, 255)));
      end
    endcase
  endtask

  initial begin
    int phase_start;
    session = new();
    rst <= 1'b1;
    req_valid <= 1'b0;
    operation <= 1'b0;
    line_byte <= 8'h00;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: lone zero length, over-long request, table request with extreme bytes.
    frame_buf = '{8'h00};
    run_exchange();
    frame_buf = '{8'h09, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF};
    run_exchange();
    fill_table(12, 1'b0);
    frame_buf[1] = 8'hFF;
    frame_buf[6] = 8'h00;
    run_exchange();

    // Random exchanges under each idling pattern; the first one starts a long hold-off.
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = SEND_IDLE[p];
      recv_stall_pct = RECV_STALL[p];
      if (p == 0) hold_trigger++;
      phase_start = requests_sent;
      while (requests_sent - phase_start < PHASE_REQUESTS) random_exchange();
    end

    // Close the session, then everything afterwards is answered with no data.
    end_session();
    repeat (6) send_request(1'(($urandom_range(0, 1))), 8'($urandom_range(0, 255)));
    req_valid <= 1'b0;

    while (session.expected.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (session.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> files.f
rtl/core/kl_resp_pkg.sv
rtl/core/k_line_ecu_packet_responder_core.sv
tb/sv/tb_top.sv
